FILE: design/etsc_pkg.sv
package etsc_pkg;

    // vertex map size, defaults for the top level
    localparam int MAX_VERTICES = 256;

    localparam int VERTEX_W = 8;

    // tour tag kept in each map entry; zero means never visited
    localparam int          EPOCH_W   = 8;
    localparam logic [7:0]  EPOCH_MIN = 8'd1;
    localparam logic [7:0]  EPOCH_MAX = 8'hFF;

    // result queue, must be a power of two and at least 4
    localparam int OUT_FIFO_DEPTH = 8;

    typedef struct packed {
        logic [VERTEX_W-1:0] path_from;
        logic [VERTEX_W-1:0] path_to;
        logic                cycle_done;
    } result_t;

    // up to two results pushed per cycle, first in slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t d0;
        result_t d1;
    } fifo_push_t;

endpackage

FILE: design/euler_tour_shortcut.sv
// Euler tour shortcutting: feed the edges of an Euler tour, one transfer per
// edge, with final_edge set on the last one; the block returns the edges of
// the Hamiltonian cycle obtained by skipping vertices already seen, and on the
// final edge the closing edge back to the start vertex with cycle_done set.
// An edge gives zero, one or two results. Sustained rate is one edge per
// cycle while in_stall is low, set by the single read-modify-write of the
// visited map per edge; a result passes the stage 1 register and the result
// queue before it leaves, and an edge that gives two results needs two
// output transfers, so a busy output back-pressures through a small result
// queue. The visited map is a RAM holding a tour tag per vertex, so ending a
// tour costs nothing; the RAM is swept clear after reset and again after
// every 255th tour, and no edge is taken during the sweep.
module euler_tour_shortcut #(
    parameter int MAX_VERTICES = etsc_pkg::MAX_VERTICES
) (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] src_vertex,
    input  logic [7:0] dst_vertex,
    input  logic       final_edge,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] path_from,
    output logic [7:0] path_to,
    output logic       cycle_done
);

    localparam int AW         = $clog2(MAX_VERTICES);
    localparam int EW         = etsc_pkg::EPOCH_W;
    localparam int VW         = etsc_pkg::VERTEX_W;
    localparam int FIFO_DEPTH = etsc_pkg::OUT_FIFO_DEPTH;
    localparam int LVL_W      = $clog2(FIFO_DEPTH) + 2;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    // ---------------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------------
    state_t        state_reg,   state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [EW-1:0] epoch_reg,   epoch_next;
    logic          tour_open_reg, tour_open_next;
    logic [VW-1:0] start_reg,   start_next;
    logic [VW-1:0] kept_reg,    kept_next;

    // stage 1: edge waiting for its map read
    logic          s1_valid_reg;
    logic [VW-1:0] s1_from_reg;
    logic [VW-1:0] s1_to_reg;
    logic          s1_final_reg;

    // last map write, which the read of the following edge cannot yet see
    logic          fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0] fwd_addr_reg;

    // ---------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------
    logic [$clog2(FIFO_DEPTH):0] fifo_level;
    logic [LVL_W-1:0]            pending;
    logic                        wrap_now;
    logic                        in_acc;

    // worst case: queued results plus two from the edge in stage 1 and two
    // from the one being taken
    assign pending  = LVL_W'(fifo_level) + (s1_valid_reg ? LVL_W'(2) : LVL_W'(0));
    // tour tag about to run out: let the sweep start with nothing in flight
    assign wrap_now = s1_valid_reg && s1_final_reg && (epoch_reg == etsc_pkg::EPOCH_MAX);
    assign in_stall = (state_reg != ST_RUN) || wrap_now
                      || (pending > LVL_W'(FIFO_DEPTH - 2));
    assign in_acc   = in_valid && !in_stall;

    // ---------------------------------------------------------------------
    // visited map
    // ---------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    etsc_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_VERTICES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (AW'(dst_vertex)),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // stage 1: decide, update the map, emit
    // ---------------------------------------------------------------------
    logic          first;
    logic [VW-1:0] start_eff;
    logic [VW-1:0] kept_eff;
    logic [AW-1:0] to_addr;
    logic          to_in_map;
    logic          seen;
    logic          new_mark;
    etsc_pkg::result_t    res_step;
    etsc_pkg::result_t    res_close;
    etsc_pkg::fifo_push_t push;

    assign first     = !tour_open_reg;
    assign start_eff = first ? s1_from_reg : start_reg;
    assign kept_eff  = first ? s1_from_reg : kept_reg;
    assign to_addr   = AW'(s1_to_reg);
    assign to_in_map = (32'(s1_to_reg) < 32'(MAX_VERTICES));

    // the start vertex is never written to the map: it is matched here
    assign seen     = (ram_rdata == epoch_reg)
                      || (fwd_valid_reg && (fwd_addr_reg == to_addr))
                      || (s1_to_reg == start_eff);
    assign new_mark = s1_valid_reg && to_in_map && !seen;

    always_comb
    begin
        res_step.path_from   = kept_eff;
        res_step.path_to     = s1_to_reg;
        res_step.cycle_done  = 1'b0;

        res_close.path_from  = new_mark ? s1_to_reg : kept_eff;
        res_close.path_to    = start_eff;
        res_close.cycle_done = 1'b1;

        push.v0 = new_mark || (s1_valid_reg && s1_final_reg);
        push.v1 = new_mark && s1_final_reg;
        push.d0 = new_mark ? res_step : res_close;
        push.d1 = res_close;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = to_addr;
        ram_wdata = epoch_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_RUN:
            begin
                ram_we = new_mark;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // tour bookkeeping and sweep sequencing
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        epoch_next     = epoch_reg;
        tour_open_next = tour_open_reg;
        start_next     = start_reg;
        kept_next      = kept_reg;
        fwd_valid_next = new_mark && !s1_final_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MAX_VERTICES - 1))
                begin
                    state_next   = ST_RUN;
                    clr_cnt_next = '0;
                    epoch_next   = etsc_pkg::EPOCH_MIN;
                end
            end
            ST_RUN:
            begin
                if (s1_valid_reg)
                begin
                    if (s1_final_reg)
                    begin
                        tour_open_next = 1'b0;
                        if (wrap_now)
                        begin
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EW'(1);
                        end
                    end
                    else
                    begin
                        tour_open_next = 1'b1;
                        start_next     = start_eff;
                        kept_next      = new_mark ? s1_to_reg : kept_eff;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            epoch_reg     <= etsc_pkg::EPOCH_MIN;
            tour_open_reg <= 1'b0;
            start_reg     <= '0;
            kept_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            epoch_reg     <= epoch_next;
            tour_open_reg <= tour_open_next;
            start_reg     <= start_next;
            kept_reg      <= kept_next;
            s1_valid_reg  <= in_acc;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_from_reg  <= src_vertex;
            s1_to_reg    <= dst_vertex;
            s1_final_reg <= final_edge;
        end
        fwd_addr_reg <= to_addr;
    end

    // ---------------------------------------------------------------------
    // result queue, output transfers
    // ---------------------------------------------------------------------
    etsc_pkg::result_t head;

    etsc_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .level     (fifo_level)
    );

    assign path_from  = head.path_from;
    assign path_to    = head.path_to;
    assign cycle_done = head.cycle_done;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_level <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (state_reg == ST_RUN))
        else $error("edge taken during map sweep");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_final_reg) |=> !tour_open_reg)
        else $error("tour left open after final edge");

    a_no_stage_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s1_valid_reg)
        else $error("edge in flight during map sweep");

endmodule

FILE: design/etsc_ram.sv
module etsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/etsc_out_fifo.sv
module etsc_out_fifo #(
    parameter int DEPTH = etsc_pkg::OUT_FIFO_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  etsc_pkg::fifo_push_t     push,
    output logic                     out_valid,
    input  logic                     out_stall,
    output etsc_pkg::result_t        head,
    output logic [$clog2(DEPTH):0]   level
);

    localparam int PW = $clog2(DEPTH);

    etsc_pkg::result_t entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg,  count_next;
    logic              pop;

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.v0) + PW'(push.v1);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push.v0) + (PW+1)'(push.v1) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            entry_reg[wr_ptr_reg] <= push.d0;
        end
        if (push.v1)
        begin
            entry_reg[wr_ptr_reg + PW'(1)] <= push.d1;
        end
    end

    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign level     = count_reg;

endmodule
